FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the indexed double-ended queue, clocked on clk and
// disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/idq_pkg.sv
// ----------------------------------------------------------------------------
// idq_pkg
// Types, codes and control structs shared by the queue controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package idq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int KIND_W        = 3;
  localparam int POS_W         = 6;
  localparam int KEY_W         = 32;
  localparam int PAYLOAD_W     = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOPOS = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [KEY_W-1:0]  entry_key;
    logic [PAYLOAD_W-1:0]     entry_payload;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [KEY_W-1:0]  out_key;
    logic [PAYLOAD_W-1:0]     out_payload;
    logic [COUNT_W-1:0]       entry_count;
    logic                     keys_sorted;
  } rsp_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic [PAYLOAD_W-1:0]     payload;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_SHIFT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_TARGET,
    RD_NEXT_POS,
    RD_AHEAD,
    RD_SCAN
  } rd_sel_t;

  typedef struct packed {
    logic    load_op;
    logic    exec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    capture;
    logic    shift_step;
    logic    scan_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_remove;
    logic empty;
    logic full;
    logic pos_bad;
    logic more_first;
    logic more_next;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

FILE: design/idq_dpath.sv
// ----------------------------------------------------------------------------
// idq_dpath
// Entry store, ring pointers, removal shifter, key order scan and result
// register of the queue.
// ----------------------------------------------------------------------------
module idq_dpath #(
  parameter int DEPTH = idq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  idq_pkg::cmd_t cmd,
  output idq_pkg::sts_t sts,
  input  idq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output idq_pkg::rsp_t rsp
);
  import idq_pkg::*;

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int PX   = CMPW + 1;
  localparam logic [PW:0]   DEPTH_P = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                         input logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_P) begin
      sum = sum - DEPTH_P;
    end
    return sum[PW-1:0];
  endfunction

  entry_t                 mem [DEPTH];
  entry_t                 rd_data;
  req_t                   op;
  logic [PW-1:0]          front;
  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          j;
  logic [STATUS_W-1:0]    status;
  logic signed [KEY_W-1:0] rkey;
  logic [PAYLOAD_W-1:0]   rpay;
  logic signed [KEY_W-1:0] prev_key;
  logic                   sorted;

  logic                   is_push;
  logic                   is_pop;
  logic                   is_remove;
  logic                   empty;
  logic                   full;
  logic                   pos_bad;
  logic                   more_first;
  logic                   more_next;
  logic [PX-1:0]          pos_x;
  logic [PX-1:0]          cnt_x;
  logic [CW-1:0]          cnt_m1;
  logic [PW-1:0]          front_inc;
  logic [PW-1:0]          front_dec;
  logic [PW-1:0]          push_slot;
  logic [PW-1:0]          rd_off;
  logic [PW-1:0]          rd_addr;
  logic                   wr_en;
  logic [PW-1:0]          wr_addr;
  entry_t                 wr_data;
  logic [STATUS_W-1:0]    status_next;
  logic                   push_ok;

  assign is_push   = (op.kind == KIND_PUSH_FRONT) || (op.kind == KIND_PUSH_BACK);
  assign is_pop    = (op.kind == KIND_POP_FRONT) || (op.kind == KIND_POP_BACK);
  assign is_remove = (op.kind == KIND_REMOVE);
  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));
  assign pos_x     = PX'(op.position);
  assign cnt_x     = PX'(count);
  assign pos_bad   = (pos_x >= cnt_x);
  assign more_first = ((pos_x + PX'(1)) < cnt_x);
  assign more_next = (({1'b0, idx} + (CW + 1)'(2)) < {1'b0, count});
  assign cnt_m1    = count - CW'(1);
  assign front_inc = (front == LAST_SLOT) ? '0 : front + PW'(1);
  assign front_dec = (front == '0) ? LAST_SLOT : front - PW'(1);
  assign push_slot = (op.kind == KIND_PUSH_FRONT) ? front_dec : slot(front, PW'(count));
  assign push_ok   = cmd.exec && is_push && !full;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_TARGET: begin
        if (op.kind == KIND_POP_FRONT) begin
          rd_off = '0;
        end else if (op.kind == KIND_POP_BACK) begin
          rd_off = PW'(cnt_m1);
        end else begin
          rd_off = PW'(op.position);
        end
      end
      RD_NEXT_POS: rd_off = PW'(pos_x + PX'(1));
      RD_AHEAD:    rd_off = PW'(idx + CW'(2));
      RD_SCAN:     rd_off = PW'(j);
      default:     rd_off = '0;
    endcase
  end

  assign rd_addr = slot(front, rd_off);
  assign wr_en   = push_ok || cmd.shift_step;
  assign wr_addr = cmd.shift_step ? slot(front, PW'(idx)) : push_slot;
  assign wr_data = cmd.shift_step ? rd_data
                                  : entry_t'{key: op.entry_key, payload: op.entry_payload};

  always_comb begin
    priority if (is_push && full) begin
      status_next = STATUS_FULL;
    end else if ((is_pop || is_remove) && empty) begin
      status_next = STATUS_EMPTY;
    end else if (is_remove && pos_bad) begin
      status_next = STATUS_NOPOS;
    end else begin
      status_next = STATUS_OK;
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // ring pointers and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (push_ok) begin
        if (op.kind == KIND_PUSH_FRONT) begin
          front <= front_dec;
        end
        count <= count + CW'(1);
      end
      if (cmd.capture) begin
        if (op.kind == KIND_POP_FRONT) begin
          front <= front_inc;
        end
        if (is_pop || (is_remove && !more_first)) begin
          count <= cnt_m1;
        end
      end
      if (cmd.shift_step && !more_next) begin
        count <= cnt_m1;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op <= req;
    end
    if (cmd.exec) begin
      status <= status_next;
      rkey   <= '0;
      rpay   <= '0;
      j      <= '0;
      sorted <= 1'b1;
    end
    if (cmd.capture) begin
      rkey <= rd_data.key;
      rpay <= rd_data.payload;
      idx  <= CW'(op.position);
    end
    if (cmd.shift_step) begin
      idx <= idx + CW'(1);
    end
    if (cmd.scan_step) begin
      if (j != '0) begin
        if ((j >= CW'(2)) && (rd_data.key < prev_key)) begin
          sorted <= 1'b0;
        end
        prev_key <= rd_data.key;
      end
      j <= j + CW'(1);
    end
    if (cmd.out_load) begin
      rsp <= '{status: status, out_key: rkey, out_payload: rpay,
               entry_count: COUNT_W'(count), keys_sorted: sorted};
    end
  end

  assign sts.is_push    = is_push;
  assign sts.is_pop     = is_pop;
  assign sts.is_remove  = is_remove;
  assign sts.empty      = empty;
  assign sts.full       = full;
  assign sts.pos_bad    = pos_bad;
  assign sts.more_first = more_first;
  assign sts.more_next  = more_next;
  assign sts.scan_end   = (j == count);
  assign sts.out_free   = !rsp_valid || !rsp_stall;

endmodule

FILE: design/idq_ctrl.sv
// ----------------------------------------------------------------------------
// idq_ctrl
// Sequencer for one queue operation: check and push, fetch, removal shift,
// key order scan and result hand-off.
// ----------------------------------------------------------------------------
module idq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  idq_pkg::sts_t sts,
  output idq_pkg::cmd_t cmd
);
  import idq_pkg::*;

  state_t state;
  state_t state_next;
  logic   take_fetch;

  assign take_fetch = (sts.is_pop && !sts.empty) ||
                      (sts.is_remove && !sts.empty && !sts.pos_bad);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = take_fetch ? ST_FETCH : ST_SCAN;
      end
      ST_FETCH: begin
        state_next = (sts.is_remove && sts.more_first) ? ST_SHIFT : ST_SCAN;
      end
      ST_SHIFT: begin
        state_next = sts.more_next ? ST_SHIFT : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_TARGET;
    unique case (state)
      ST_IDLE: begin
        cmd.load_op = req_valid;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        cmd.rd_en = 1'b1;
      end
      ST_FETCH: begin
        cmd.capture = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_NEXT_POS;
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_AHEAD;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_SCAN;
      end
      ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  assign req_stall = (state != ST_IDLE);

endmodule

FILE: design/indexed_double_ended_queue.sv
// ----------------------------------------------------------------------------
// indexed_double_ended_queue
// Bounded double-ended queue of key and payload entries with push and pop at
// both ends, removal at a position and a key order report on every result.
//
//   channel  signals                   transfer when
//   req      req_valid req_stall req   req_valid and not req_stall
//   rsp      rsp_valid rsp_stall rsp   rsp_valid and not rsp_stall
//
// push and query results are set by the key order scan, which reads one stored
// key per cycle over the entries held afterwards; pops and removals add a fetch
// of the target entry, and a removal then shifts each entry behind the removed
// position one place toward the front
// one operation at a time; a new request is taken while the last result waits
// reset is synchronous and empties the queue; the entry store is not cleared
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_double_ended_queue #(
  parameter int DEPTH = idq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  idq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output idq_pkg::rsp_t rsp
);
  import idq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  idq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  idq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `IDQ_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall, "took second request")
  `IDQ_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !rsp_valid || !rsp_stall, "result overwritten")
  `IDQ_ASSERT_IMPL(a_shift_remove, cmd.shift_step, sts.is_remove, "shift outside removal")

endmodule

FILE: tb/sv/indexed_double_ended_queue_test.sv
// ----------------------------------------------------------------------------
// indexed_double_ended_queue_test
// Self-checking bench for the indexed double-ended queue. A shadow deque
// predicts the result of every request transfer. Directed requests cover the
// empty and no-such-position cases, key extremes and the spare kind codes. Random
// phases then fill, drain and mix operations with random or ordered keys, while
// both channels idle in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module indexed_double_ended_queue_test;
  import idq_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 630;
  localparam int CALM_FROM    = RANDOM_ITEMS - 60;
  localparam int SETTLE       = 200;
  localparam int LIMIT_CYCLES = 1000000;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam int PHASE_FILL  = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  localparam int KEYS_RANDOM  = 0;
  localparam int KEYS_NARROW  = 1;
  localparam int KEYS_ORDERED = 2;

  class deque_shadow;
    entry_t held_entries[$];
    rsp_t   expected_results[$];
    int     failures;
    int     status_hits[4];
    int     peak_count;
    int     sorted_hits;

    function bit keys_ordered();
      for (int i = 1; i < held_entries.size(); i++) begin
        if (held_entries[i].key < held_entries[i-1].key) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      rsp_t   want;
      entry_t ent;
      want = '0;
      want.status = STATUS_OK;
      case (r.kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (held_entries.size() >= DEPTH) begin
            want.status = STATUS_FULL;
          end else begin
            ent.key = r.entry_key;
            ent.payload = r.entry_payload;
            if (r.kind == KIND_PUSH_FRONT) held_entries.push_front(ent);
            else held_entries.push_back(ent);
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (held_entries.size() == 0) begin
            want.status = STATUS_EMPTY;
          end else begin
            if (r.kind == KIND_POP_FRONT) ent = held_entries.pop_front();
            else ent = held_entries.pop_back();
            want.out_key = ent.key;
            want.out_payload = ent.payload;
          end
        end
        KIND_REMOVE: begin
          if (held_entries.size() == 0) begin
            want.status = STATUS_EMPTY;
          end else if (r.position >= held_entries.size()) begin
            want.status = STATUS_NOPOS;
          end else begin
            ent = held_entries[r.position];
            held_entries.delete(r.position);
            want.out_key = ent.key;
            want.out_payload = ent.payload;
          end
        end
        default: begin
        end
      endcase
      want.entry_count = COUNT_W'(held_entries.size());
      want.keys_sorted = keys_ordered();
      status_hits[want.status]++;
      if (held_entries.size() > peak_count) peak_count = held_entries.size();
      if (want.keys_sorted && held_entries.size() > 1) sorted_hits++;
      expected_results.push_back(want);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_results.size() == 0) begin
        $error("result transfer with no request outstanding: %p", got);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("out_key", want.out_key, got.out_key);
      check_field("out_payload", want.out_payload, got.out_payload);
      check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      check_field("keys_sorted", 32'(want.keys_sorted), 32'(got.keys_sorted));
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  deque_shadow shadow;
  bit          idle_on;
  int          est_count;
  int          items_sent;
  int          results_seen;
  int          front_key;
  int          back_key;

  indexed_double_ended_queue u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (req_valid && !req_stall) shadow.note_request(req);
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        shadow.check_result(rsp);
      end
    end
  end

  // receiver back-pressure in bursts
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("Mismatches found");
    $finish;
  end

  function automatic req_t make_req(logic [KIND_W-1:0] kind, logic [POS_W-1:0] position,
                                    logic [KEY_W-1:0] key, logic [PAYLOAD_W-1:0] payload);
    req_t r;
    r.kind = kind;
    r.position = position;
    r.entry_key = key;
    r.entry_payload = payload;
    return r;
  endfunction

  task automatic issue(input req_t r);
    if (items_sent >= CALM_FROM) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
    case (r.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: if (est_count < DEPTH) est_count++;
      KIND_POP_FRONT, KIND_POP_BACK: if (est_count > 0) est_count--;
      KIND_REMOVE: if (r.position < est_count) est_count--;
      default: ;
    endcase
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int mode, logic [KIND_W-1:0] kind);
    case (mode)
      KEYS_NARROW: return $urandom_range(0, 8) - 4;
      KEYS_ORDERED: begin
        if (kind == KIND_PUSH_FRONT) begin
          front_key -= $urandom_range(0, 3);
          return front_key;
        end
        back_key += $urandom_range(0, 3);
        return back_key;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic random_op(input logic [KIND_W-1:0] kind, input int key_mode);
    logic [POS_W-1:0] position;
    if (est_count > 0 && $urandom_range(0, 9) != 0) begin
      position = POS_W'($urandom_range(0, est_count - 1));
    end else begin
      position = POS_W'($urandom);
    end
    issue(make_req(kind, position, pick_key(key_mode, kind), $urandom));
  endtask

  initial begin
    int                phase;
    int                key_mode;
    int                n;
    int                guard;
    logic [KIND_W-1:0] kind;

    shadow = new();
    idle_on = 1'b1;
    est_count = 0;
    items_sent = 0;
    results_seen = 0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty queue cases, key and payload extremes, spare kinds
    issue(make_req(KIND_QUERY, '0, '0, '0));
    issue(make_req(KIND_POP_FRONT, '0, '0, '0));
    issue(make_req(KIND_POP_BACK, '1, '1, '1));
    issue(make_req(KIND_REMOVE, '0, '0, '0));
    issue(make_req(KIND_PUSH_BACK, '0, 32'h7fff_ffff, 32'hffff_ffff));
    issue(make_req(KIND_PUSH_FRONT, '1, 32'h8000_0000, 32'h0000_0000));
    issue(make_req(KIND_PUSH_BACK, '0, 32'h0000_0000, 32'h5a5a_a5a5));
    issue(make_req(KIND_REMOVE, 6'd63, '0, '0));
    issue(make_req(KIND_REMOVE, 6'd3, '0, '0));
    issue(make_req(KIND_REMOVE, 6'd2, '0, '0));
    issue(make_req(KIND_PUSH_BACK, '0, 32'hffff_ffff, 32'h1234_5678));
    issue(make_req(KIND_PUSH_BACK, '0, 32'hffff_ffff, 32'h8765_4321));
    issue(make_req(KIND_PUSH_FRONT, '0, 32'h8000_0000, 32'hdead_beef));
    issue(make_req(KIND_REMOVE, 6'd1, '0, '0));
    issue(make_req(KIND_REMOVE, 6'd0, '0, '0));
    issue(make_req(KIND_SPARE_LO, '1, '1, '1));
    issue(make_req(KIND_POP_BACK, '0, '0, '0));
    issue(make_req(KIND_POP_FRONT, '0, '0, '0));
    issue(make_req(KIND_SPARE_HI, '0, '0, '0));
    issue(make_req(KIND_POP_FRONT, '0, '0, '0));

    items_sent = 0;
    phase = PHASE_FILL;
    while (items_sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      key_mode = $urandom_range(KEYS_RANDOM, KEYS_ORDERED);
      front_key = $urandom_range(0, 2000) - 1000;
      back_key = front_key;
      case (phase)
        PHASE_FILL: begin
          n = $urandom_range(10, 72);
          repeat (n) begin
            if ($urandom_range(0, 9) == 0) kind = KIND_W'($urandom);
            else if ($urandom_range(0, 1) == 0) kind = KIND_PUSH_FRONT;
            else kind = KIND_PUSH_BACK;
            random_op(kind, key_mode);
          end
          if (est_count == DEPTH) issue(make_req(KIND_REMOVE, 6'd63, '0, '0));
        end
        PHASE_DRAIN: begin
          guard = 0;
          while (est_count > 0 && guard < 120) begin
            guard++;
            case ($urandom_range(0, 9))
              0: kind = KIND_W'($urandom);
              1, 2, 3: kind = KIND_POP_FRONT;
              4, 5, 6: kind = KIND_POP_BACK;
              default: kind = KIND_REMOVE;
            endcase
            random_op(kind, key_mode);
          end
          repeat ($urandom_range(1, 3)) begin
            random_op(KIND_W'($urandom_range(KIND_POP_FRONT, KIND_REMOVE)), key_mode);
          end
        end
        default: begin
          n = $urandom_range(20, 50);
          repeat (n) random_op(KIND_W'($urandom), key_mode);
        end
      endcase
      phase = (items_sent < 80) ? PHASE_DRAIN : $urandom_range(PHASE_FILL, PHASE_MIXED);
      if (items_sent < 80 && est_count == 0) phase = PHASE_FILL;
    end

    req_valid <= 1'b0;
    idle_on = 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d results checked; ok %0d, empty %0d, no position %0d, full %0d",
             results_seen, shadow.status_hits[STATUS_OK], shadow.status_hits[STATUS_EMPTY],
             shadow.status_hits[STATUS_NOPOS], shadow.status_hits[STATUS_FULL]);
    $display("peak fill %0d of %0d, ordered keys over two or more entries %0d times",
             shadow.peak_count, DEPTH, shadow.sorted_hits);
    if (shadow.failures == 0 && shadow.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/idq_pkg.sv
design/idq_dpath.sv
design/idq_ctrl.sv
design/indexed_double_ended_queue.sv
tb/sv/indexed_double_ended_queue_test.sv
